@@ design/dma4_pkg.sv @@
// ============================================================================
// dma4_pkg: shared types and constants of the four-channel DMA controller
// Opcodes, control register fields, channel command and status records, and
// the length and address step helpers.
// ============================================================================
package dma4_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int LONG_CHANNEL     = 3;

    localparam int ADDR_W  = 32;
    localparam int REG_W   = 16;
    localparam int COUNT_W = 17;
    localparam int CH_W    = 2;
    localparam int TIM_W   = 2;
    localparam int OP_W    = 3;

    localparam logic [COUNT_W-1:0] MAX_SHORT = 17'h04000;
    localparam logic [COUNT_W-1:0] MAX_LONG  = 17'h10000;

    // Control register bit positions.
    localparam int CTRL_DMODE_LO  = 5;
    localparam int CTRL_SMODE_LO  = 7;
    localparam int CTRL_REPEAT    = 9;
    localparam int CTRL_WORD      = 10;
    localparam int CTRL_TIMING_LO = 12;
    localparam int CTRL_IRQ_EN    = 14;
    localparam int CTRL_ENABLE    = 15;

    typedef enum logic [OP_W-1:0] {
        OP_WR_LEN  = 3'd0,
        OP_WR_SRC  = 3'd1,
        OP_WR_DST  = 3'd2,
        OP_WR_CTRL = 3'd3,
        OP_RD_LEN  = 3'd4,
        OP_RD_CTRL = 3'd5,
        OP_TRIGGER = 3'd6,
        OP_TICK    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        AM_INC    = 2'd0,
        AM_DEC    = 2'd1,
        AM_FIXED  = 2'd2,
        AM_RELOAD = 2'd3
    } addr_mode_t;

    localparam logic [TIM_W-1:0] TIM_IMMEDIATE = 2'd0;

    // Command as seen by one channel for one accepted item.
    typedef struct packed {
        logic              accept;
        op_t               op;
        logic              hit;
        logic              grant;
        logic [ADDR_W-1:0] value;
        logic [ADDR_W-1:0] mask;
        logic [TIM_W-1:0]  timing;
    } chan_cmd_t;

    // What one channel reports back.
    typedef struct packed {
        logic              request;
        logic [REG_W-1:0]  length;
        logic [REG_W-1:0]  control;
        logic              copy_valid;
        logic [ADDR_W-1:0] copy_source;
        logic [ADDR_W-1:0] copy_dest;
        logic              copy_word;
        logic              irq;
    } chan_stat_t;

    typedef struct packed {
        logic [REG_W-1:0]  read_data;
        logic              copy_valid;
        logic [ADDR_W-1:0] copy_source;
        logic [ADDR_W-1:0] copy_dest;
        logic              copy_word;
        logic              irq_valid;
        logic [CH_W-1:0]   irq_channel;
    } result_t;

    function automatic logic [COUNT_W-1:0] decode_len(input logic is_long,
                                                      input logic [REG_W-1:0] len);
        logic [COUNT_W-1:0] res;
        if (len != '0)
            res = {1'b0, len};
        else if (is_long)
            res = MAX_LONG;
        else
            res = MAX_SHORT;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] step_addr(input logic [ADDR_W-1:0] addr,
                                                    input logic [1:0] mode,
                                                    input logic word);
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] res;
        step = word ? ADDR_W'(4) : ADDR_W'(2);
        case (addr_mode_t'(mode))
            AM_DEC:   res = addr - step;
            AM_FIXED: res = addr;
            default:  res = addr + step;
        endcase
        return res;
    endfunction

endpackage

@@ design/dma4_cmd_if.sv @@
// ============================================================================
// dma4_cmd_if: command channel of the DMA controller
// Valid/ready channel carrying one register access, trigger or tick per item.
// ============================================================================
interface dma4_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [dma4_pkg::OP_W-1:0]   opcode;
    logic [dma4_pkg::CH_W-1:0]   channel;
    logic [dma4_pkg::ADDR_W-1:0] value;
    logic [dma4_pkg::ADDR_W-1:0] mask;
    logic [dma4_pkg::TIM_W-1:0]  timing;

    modport source (output valid, opcode, channel, value, mask, timing, input ready);
    modport sink   (input valid, opcode, channel, value, mask, timing, output ready);
endinterface

@@ design/dma4_rsp_if.sv @@
// ============================================================================
// dma4_rsp_if: result channel of the DMA controller
// Valid/ready channel carrying read data, copy commands and interrupts.
// ============================================================================
interface dma4_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [dma4_pkg::REG_W-1:0]  read_data;
    logic                       copy_valid;
    logic [dma4_pkg::ADDR_W-1:0] copy_source;
    logic [dma4_pkg::ADDR_W-1:0] copy_dest;
    logic                       copy_word;
    logic                       irq_valid;
    logic [dma4_pkg::CH_W-1:0]   irq_channel;

    modport source (output valid, read_data, copy_valid, copy_source, copy_dest, copy_word,
                    irq_valid, irq_channel, input ready);
    modport sink   (input valid, read_data, copy_valid, copy_source, copy_dest, copy_word,
                    irq_valid, irq_channel, output ready);
endinterface

@@ design/four_channel_dma_controller.sv @@
// ============================================================================
// four_channel_dma_controller: multi-channel DMA controller top level
// Register access, triggers and ticks in; read data, element copy commands
// and interrupts out, one result item for every command item.
// ============================================================================
//
//   Channel   Direction   Item carries
//   -------   ---------   ---------------------------------------------------
//   cmd       in          opcode, channel, value, mask, timing
//   rsp       out         read_data, copy_valid/source/dest/word, irq_valid/channel
//
// Every command item is finished in the cycle it is accepted: the channel
// registers update at that clock edge and the result item is loaded into the
// result register (the skid stage if the result side stalls), so one item
// per cycle is sustained while cmd.ready is high. The result register plus a
// skid stage hold two results; cmd.ready drops only when both are full. Reset
// is asynchronous and clears all channel registers and both result slots.
//
module four_channel_dma_controller #(
    parameter int NUM_CHANNELS = dma4_pkg::NUM_CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dma4_cmd_if.sink      cmd,
    dma4_rsp_if.source    rsp
);

    // Per-channel command and status records.
    dma4_pkg::chan_cmd_t  chan_cmd  [NUM_CHANNELS];
    dma4_pkg::chan_stat_t chan_stat [NUM_CHANNELS];

    logic [NUM_CHANNELS-1:0] req;
    logic [NUM_CHANNELS-1:0] gnt;
    logic                    accept;
    logic                    can_push;
    dma4_pkg::op_t           op;
    dma4_pkg::result_t       res;
    dma4_pkg::result_t       out_data;

    assign op     = dma4_pkg::op_t'(cmd.opcode);
    assign accept = cmd.valid && cmd.ready;
    assign cmd.ready = can_push;

    // The tick grant goes to the lowest-numbered pending, enabled channel.
    dma4_arb #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_arb (
        .tick (accept && op == dma4_pkg::OP_TICK),
        .req  (req),
        .gnt  (gnt)
    );

    // Channels above the channel field's reach are simply never addressed.
    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            chan_cmd[i].accept = accept;
            chan_cmd[i].op     = op;
            chan_cmd[i].hit    = (int'(cmd.channel) == i);
            chan_cmd[i].grant  = gnt[i];
            chan_cmd[i].value  = cmd.value;
            chan_cmd[i].mask   = cmd.mask;
            chan_cmd[i].timing = cmd.timing;
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_chan
        dma4_chan #(
            .IS_LONG(g == dma4_pkg::LONG_CHANNEL)
        ) u_chan (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (chan_cmd[g]),
            .stat  (chan_stat[g])
        );
        assign req[g] = chan_stat[g].request;
    end

    // Assemble the result item. Only the granted channel drives its copy
    // and interrupt fields, so an OR across channels selects it.
    always_comb
    begin
        res = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (int'(cmd.channel) == i)
            begin
                if (op == dma4_pkg::OP_RD_LEN)
                    res.read_data = chan_stat[i].length;
                else if (op == dma4_pkg::OP_RD_CTRL)
                    res.read_data = chan_stat[i].control;
            end
            res.copy_valid  = res.copy_valid  | chan_stat[i].copy_valid;
            res.copy_source = res.copy_source | chan_stat[i].copy_source;
            res.copy_dest   = res.copy_dest   | chan_stat[i].copy_dest;
            res.copy_word   = res.copy_word   | chan_stat[i].copy_word;
            if (chan_stat[i].irq)
            begin
                res.irq_valid   = 1'b1;
                res.irq_channel = dma4_pkg::CH_W'(i);
            end
        end
    end

    dma4_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.read_data   = out_data.read_data;
    assign rsp.copy_valid  = out_data.copy_valid;
    assign rsp.copy_source = out_data.copy_source;
    assign rsp.copy_dest   = out_data.copy_dest;
    assign rsp.copy_word   = out_data.copy_word;
    assign rsp.irq_valid   = out_data.irq_valid;
    assign rsp.irq_channel = out_data.irq_channel;

    // At most one channel is granted a tick.
    a_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(gnt))
        else $error("more than one channel granted");

    // A grant only happens on an accepted tick, and only to a requester.
    a_grant_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (gnt != '0) |-> (accept && op == dma4_pkg::OP_TICK && (gnt & ~req) == '0))
        else $error("grant without accepted tick or request");

    // Every accepted item leaves a result behind at the next edge.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("accepted item produced no result");

    // A copy address set without copy_valid would mean a channel drove it with no copy.
    a_copy_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.copy_valid) |-> (rsp.copy_source == '0 && rsp.copy_dest == '0))
        else $error("copy address without copy_valid");

endmodule

@@ design/dma4_chan.sv @@
// ============================================================================
// dma4_chan: one DMA channel
// Holds the channel registers and working state and applies one item to them.
// ============================================================================
module dma4_chan #(
    parameter bit IS_LONG = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dma4_pkg::chan_cmd_t  cmd,
    output dma4_pkg::chan_stat_t stat
);

    logic [dma4_pkg::REG_W-1:0]   len_reg,   len_next;
    logic [dma4_pkg::ADDR_W-1:0]  src_reg,   src_next;
    logic [dma4_pkg::ADDR_W-1:0]  dst_reg,   dst_next;
    logic [dma4_pkg::REG_W-1:0]   ctrl_reg,  ctrl_next;
    logic [dma4_pkg::COUNT_W-1:0] cnt_reg,   cnt_next;
    logic [dma4_pkg::ADDR_W-1:0]  wsrc_reg,  wsrc_next;
    logic [dma4_pkg::ADDR_W-1:0]  wdst_reg,  wdst_next;
    logic                         pend_reg,  pend_next;

    logic [dma4_pkg::REG_W-1:0]   mask16;
    logic [dma4_pkg::REG_W-1:0]   ctrl_wr;
    logic [dma4_pkg::COUNT_W-1:0] cnt_left;
    logic                         word;
    logic [1:0]                   dmode;

    assign mask16 = cmd.mask[dma4_pkg::REG_W-1:0];
    assign ctrl_wr = (ctrl_reg & ~mask16) | (cmd.value[dma4_pkg::REG_W-1:0] & mask16);
    assign word = ctrl_reg[dma4_pkg::CTRL_WORD];
    assign dmode = ctrl_reg[dma4_pkg::CTRL_DMODE_LO +: 2];
    assign cnt_left = (cnt_reg == '0) ? '0 : cnt_reg - 1'b1;

    always_comb
    begin
        len_next  = len_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        ctrl_next = ctrl_reg;
        cnt_next  = cnt_reg;
        wsrc_next = wsrc_reg;
        wdst_next = wdst_reg;
        pend_next = pend_reg;

        stat.request     = pend_reg && ctrl_reg[dma4_pkg::CTRL_ENABLE];
        stat.length      = len_reg;
        stat.control     = ctrl_reg;
        stat.copy_valid  = 1'b0;
        stat.copy_source = '0;
        stat.copy_dest   = '0;
        stat.copy_word   = 1'b0;
        stat.irq         = 1'b0;

        if (cmd.accept)
        begin
            unique case (cmd.op)
                dma4_pkg::OP_WR_LEN:
                begin
                    if (cmd.hit)
                    begin
                        len_next = (len_reg & ~mask16) | (cmd.value[dma4_pkg::REG_W-1:0] & mask16);
                        cnt_next = dma4_pkg::decode_len(IS_LONG, len_next);
                    end
                end
                dma4_pkg::OP_WR_SRC:
                begin
                    if (cmd.hit)
                        src_next = (src_reg & ~cmd.mask) | (cmd.value & cmd.mask);
                end
                dma4_pkg::OP_WR_DST:
                begin
                    if (cmd.hit)
                        dst_next = (dst_reg & ~cmd.mask) | (cmd.value & cmd.mask);
                end
                dma4_pkg::OP_WR_CTRL:
                begin
                    if (cmd.hit)
                    begin
                        ctrl_next = ctrl_wr;
                        if (!ctrl_wr[dma4_pkg::CTRL_ENABLE])
                            pend_next = 1'b0;
                        else if (!ctrl_reg[dma4_pkg::CTRL_ENABLE])
                        begin
                            wsrc_next = src_reg;
                            wdst_next = dst_reg;
                            if (ctrl_wr[dma4_pkg::CTRL_TIMING_LO +: dma4_pkg::TIM_W]
                                == dma4_pkg::TIM_IMMEDIATE)
                                pend_next = 1'b1;
                        end
                    end
                end
                dma4_pkg::OP_TRIGGER:
                begin
                    if (ctrl_reg[dma4_pkg::CTRL_ENABLE]
                        && ctrl_reg[dma4_pkg::CTRL_TIMING_LO +: dma4_pkg::TIM_W] == cmd.timing)
                        pend_next = 1'b1;
                end
                dma4_pkg::OP_TICK:
                begin
                    if (cmd.grant)
                    begin
                        cnt_next = cnt_left;
                        if (cnt_reg != '0)
                        begin
                            stat.copy_valid  = 1'b1;
                            stat.copy_source = wsrc_reg;
                            stat.copy_dest   = wdst_reg;
                            stat.copy_word   = word;
                            wsrc_next = dma4_pkg::step_addr(wsrc_reg,
                                            ctrl_reg[dma4_pkg::CTRL_SMODE_LO +: 2], word);
                            wdst_next = dma4_pkg::step_addr(wdst_reg, dmode, word);
                        end
                        if (cnt_left == '0)
                        begin
                            stat.irq  = ctrl_reg[dma4_pkg::CTRL_IRQ_EN];
                            pend_next = 1'b0;
                            cnt_next  = dma4_pkg::decode_len(IS_LONG, len_reg);
                            if (ctrl_reg[dma4_pkg::CTRL_REPEAT]
                                && ctrl_reg[dma4_pkg::CTRL_TIMING_LO +: dma4_pkg::TIM_W]
                                   != dma4_pkg::TIM_IMMEDIATE)
                            begin
                                if (dma4_pkg::addr_mode_t'(dmode) == dma4_pkg::AM_RELOAD)
                                    wdst_next = dst_reg;
                            end
                            else
                                ctrl_next[dma4_pkg::CTRL_ENABLE] = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // Register reads leave the channel state untouched.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            src_reg  <= '0;
            dst_reg  <= '0;
            ctrl_reg <= '0;
            cnt_reg  <= '0;
            wsrc_reg <= '0;
            wdst_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            src_reg  <= src_next;
            dst_reg  <= dst_next;
            ctrl_reg <= ctrl_next;
            cnt_reg  <= cnt_next;
            wsrc_reg <= wsrc_next;
            wdst_reg <= wdst_next;
            pend_reg <= pend_next;
        end
    end

endmodule

@@ design/dma4_arb.sv @@
// ============================================================================
// dma4_arb: fixed-priority tick arbiter
// Grants the lowest-numbered requesting channel when a tick is accepted.
// ============================================================================
module dma4_arb #(
    parameter int NUM_CHANNELS = dma4_pkg::NUM_CHANNELS_DEF
) (
    input  logic                    tick,
    input  logic [NUM_CHANNELS-1:0] req,
    output logic [NUM_CHANNELS-1:0] gnt
);

    logic found;

    always_comb
    begin
        gnt   = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (tick && req[i] && !found)
            begin
                gnt[i] = 1'b1;
                found  = 1'b1;
            end
        end
    end

endmodule

@@ design/dma4_outq.sv @@
// ============================================================================
// dma4_outq: result register with skid stage
// Holds up to two results so the command side can hand over one more
// result while the result side stalls.
// ============================================================================
module dma4_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dma4_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output dma4_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    dma4_pkg::result_t out_data_reg;
    dma4_pkg::result_t skid_data_reg;
    logic              out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

endmodule

@@ verif/tb_four_channel_dma_controller.sv @@
// ============================================================================
// tb_four_channel_dma_controller: self-checking bench for the DMA controller
// Drives register accesses, timing triggers and ticks through the command
// channel and checks every result item against a cycle-free predictor of the
// four channels kept inside the bench.
// ============================================================================
`timescale 1ns / 1ps

module tb_four_channel_dma_controller;

    localparam int CHANS       = dma4_pkg::NUM_CHANNELS_DEF;
    localparam int ITEM_TARGET = 1200;
    // Once the backlog drops below this many items, neither side idles.
    localparam int TAIL_ITEMS  = 150;
    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT = 500;
    localparam int MAX_REPORTS = 10;

    localparam int TIM_W   = dma4_pkg::TIM_W;
    localparam int ADDR_W  = dma4_pkg::ADDR_W;
    localparam int REG_W   = dma4_pkg::REG_W;
    localparam int COUNT_W = dma4_pkg::COUNT_W;
    localparam int CH_W    = dma4_pkg::CH_W;

    localparam logic [TIM_W-1:0] TIM_NOW     = dma4_pkg::TIM_IMMEDIATE;
    localparam logic [TIM_W-1:0] TIM_VBLANK  = 2'd1;
    localparam logic [TIM_W-1:0] TIM_HBLANK  = 2'd2;
    localparam logic [TIM_W-1:0] TIM_SPECIAL = 2'd3;

    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] LOW_HALF = 32'h0000_FFFF;
    localparam logic [ADDR_W-1:0] EN_BIT   = 32'h1 << dma4_pkg::CTRL_ENABLE;

    localparam int C_EN  = dma4_pkg::CTRL_ENABLE;
    localparam int C_IRQ = dma4_pkg::CTRL_IRQ_EN;
    localparam int C_TIM = dma4_pkg::CTRL_TIMING_LO;
    localparam int C_WRD = dma4_pkg::CTRL_WORD;
    localparam int C_RPT = dma4_pkg::CTRL_REPEAT;
    localparam int C_SM  = dma4_pkg::CTRL_SMODE_LO;
    localparam int C_DM  = dma4_pkg::CTRL_DMODE_LO;

    // One command item as the bench keeps it.
    typedef struct packed {
        dma4_pkg::op_t     op;
        logic [CH_W-1:0]   ch;
        logic [ADDR_W-1:0] value;
        logic [ADDR_W-1:0] mask;
        logic [TIM_W-1:0]  timing;
    } cmd_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dma4_cmd_if cmd_bus ();
    dma4_rsp_if rsp_bus ();

    four_channel_dma_controller DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a shadow copy of every channel's registers.
    // ------------------------------------------------------------------------
    logic [REG_W-1:0]   len_r   [CHANS] = '{default: '0};
    logic [ADDR_W-1:0]  src_r   [CHANS] = '{default: '0};
    logic [ADDR_W-1:0]  dst_r   [CHANS] = '{default: '0};
    logic [REG_W-1:0]   ctl_r   [CHANS] = '{default: '0};
    logic [COUNT_W-1:0] left    [CHANS] = '{default: '0};
    logic [ADDR_W-1:0]  cur_src [CHANS] = '{default: '0};
    logic [ADDR_W-1:0]  cur_dst [CHANS] = '{default: '0};
    logic               armed   [CHANS] = '{default: 1'b0};

    cmd_item_t         cmd_backlog [$];    // items still to be driven
    dma4_pkg::result_t predicted_rsp [$];  // results owed by the block, oldest first
    cmd_item_t         in_flight;          // item currently on the command channel

    int  items_made    = 0;
    int  accepted_cmds = 0;
    int  fail_count    = 0;
    int  cmd_gap       = 0;
    int  rsp_gap       = 0;
    int  idle_cycles   = 0;
    // quiet: the idle-free tail of the run. calm: a stretch with no idling.
    logic quiet = 1'b0;
    logic calm  = 1'b0;

    function automatic logic [ADDR_W-1:0] masked_write(input logic [ADDR_W-1:0] old,
                                                       input logic [ADDR_W-1:0] v,
                                                       input logic [ADDR_W-1:0] m);
        return (old & ~m) | (v & m);
    endfunction

    // A programmed length of zero stands for the largest transfer, which is
    // four times bigger on the last channel.
    function automatic logic [COUNT_W-1:0] elements_of(input int ch,
                                                       input logic [REG_W-1:0] len);
        if (len != '0)
            return {1'b0, len};
        return (ch == dma4_pkg::LONG_CHANNEL) ? dma4_pkg::MAX_LONG : dma4_pkg::MAX_SHORT;
    endfunction

    function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] addr,
                                                    input logic [1:0] mode,
                                                    input logic word);
        logic [ADDR_W-1:0] stride;
        stride = word ? 32'd4 : 32'd2;
        if (dma4_pkg::addr_mode_t'(mode) == dma4_pkg::AM_DEC)
            return addr - stride;
        if (dma4_pkg::addr_mode_t'(mode) == dma4_pkg::AM_FIXED)
            return addr;
        return addr + stride;
    endfunction

    function automatic logic [REG_W-1:0] make_ctrl(input logic on, input logic irq,
                                                   input logic [TIM_W-1:0] tim,
                                                   input logic word, input logic rpt,
                                                   input dma4_pkg::addr_mode_t smode,
                                                   input dma4_pkg::addr_mode_t dmode);
        logic [REG_W-1:0] c;
        c = '0;
        c[C_EN]          = on;
        c[C_IRQ]         = irq;
        c[C_TIM +: TIM_W] = tim;
        c[C_WRD]         = word;
        c[C_RPT]         = rpt;
        c[C_SM +: 2]     = smode;
        c[C_DM +: 2]     = dmode;
        return c;
    endfunction

    // Applies one accepted command item to the shadow channels and returns
    // the result item the block owes for it.
    function automatic dma4_pkg::result_t compute_rsp(input cmd_item_t it);
        dma4_pkg::result_t r;
        int                c;
        int                i;
        int                sel;
        logic [REG_W-1:0]  ctl;
        logic              was_on;
        r   = '0;
        c   = int'(it.ch);
        sel = -1;
        case (it.op)
            dma4_pkg::OP_WR_LEN:
            begin
                len_r[c] = REG_W'(masked_write({16'h0, len_r[c]}, it.value, it.mask));
                left[c]  = elements_of(c, len_r[c]);
            end
            dma4_pkg::OP_WR_SRC: src_r[c] = masked_write(src_r[c], it.value, it.mask);
            dma4_pkg::OP_WR_DST: dst_r[c] = masked_write(dst_r[c], it.value, it.mask);
            dma4_pkg::OP_WR_CTRL:
            begin
                was_on   = ctl_r[c][C_EN];
                ctl_r[c] = REG_W'(masked_write({16'h0, ctl_r[c]}, it.value, it.mask));
                if (!ctl_r[c][C_EN])
                    armed[c] = 1'b0;
                else if (!was_on)
                begin
                    // Rising enable latches the working addresses.
                    cur_src[c] = src_r[c];
                    cur_dst[c] = dst_r[c];
                    if (ctl_r[c][C_TIM +: TIM_W] == TIM_NOW)
                        armed[c] = 1'b1;
                end
            end
            dma4_pkg::OP_RD_LEN:  r.read_data = len_r[c];
            dma4_pkg::OP_RD_CTRL: r.read_data = ctl_r[c];
            dma4_pkg::OP_TRIGGER:
            begin
                for (i = 0; i < CHANS; i++)
                    if (ctl_r[i][C_EN] && ctl_r[i][C_TIM +: TIM_W] == it.timing)
                        armed[i] = 1'b1;
            end
            default:
            begin
                // Tick: the lowest-numbered armed and enabled channel wins.
                for (i = CHANS - 1; i >= 0; i--)
                    if (armed[i] && ctl_r[i][C_EN])
                        sel = i;
                if (sel >= 0)
                begin
                    ctl = ctl_r[sel];
                    if (left[sel] != '0)
                    begin
                        r.copy_valid  = 1'b1;
                        r.copy_source = cur_src[sel];
                        r.copy_dest   = cur_dst[sel];
                        r.copy_word   = ctl[C_WRD];
                        cur_src[sel]  = next_addr(cur_src[sel], ctl[C_SM +: 2], ctl[C_WRD]);
                        cur_dst[sel]  = next_addr(cur_dst[sel], ctl[C_DM +: 2], ctl[C_WRD]);
                        left[sel]     = left[sel] - 1'b1;
                    end
                    // A zero count (no length written since reset) completes
                    // the channel at once without a copy.
                    if (left[sel] == '0)
                    begin
                        if (ctl[C_IRQ])
                        begin
                            r.irq_valid   = 1'b1;
                            r.irq_channel = CH_W'(sel);
                        end
                        armed[sel] = 1'b0;
                        left[sel]  = elements_of(sel, len_r[sel]);
                        if (ctl[C_RPT] && ctl[C_TIM +: TIM_W] != TIM_NOW)
                        begin
                            if (dma4_pkg::addr_mode_t'(ctl[C_DM +: 2]) == dma4_pkg::AM_RELOAD)
                                cur_dst[sel] = dst_r[sel];
                        end
                        else
                            ctl_r[sel][C_EN] = 1'b0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_item(input dma4_pkg::op_t op, input int ch,
                            input logic [ADDR_W-1:0] v,
                            input logic [ADDR_W-1:0] m, input logic [TIM_W-1:0] t);
        cmd_item_t it;
        it.op     = op;
        it.ch     = CH_W'(ch);
        it.value  = v;
        it.mask   = m;
        it.timing = t;
        cmd_backlog.push_back(it);
        items_made++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents backlog items on the command channel, with random idle
    // bursts between items, and feeds every accepted item to the predictor.
    // A new item is loaded only when the channel is empty or the current item
    // is taken at this edge, so valid never drops under a waiting item.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid   <= 1'b0;
            cmd_bus.opcode  <= dma4_pkg::OP_RD_LEN;
            cmd_bus.channel <= '0;
            cmd_bus.value   <= '0;
            cmd_bus.mask    <= '0;
            cmd_bus.timing  <= TIM_NOW;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                predicted_rsp.push_back(compute_rsp(in_flight));
                accepted_cmds++;
                // Every 50 items decide afresh whether the next stretch idles.
                if (accepted_cmds % 50 == 0)
                    calm <= ($urandom_range(0, 3) == 0);
            end
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (cmd_gap != 0)
                begin
                    cmd_gap--;
                    cmd_bus.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    in_flight = cmd_backlog.pop_front();
                    cmd_bus.valid   <= 1'b1;
                    cmd_bus.opcode  <= in_flight.op;
                    cmd_bus.channel <= in_flight.ch;
                    cmd_bus.value   <= in_flight.value;
                    cmd_bus.mask    <= in_flight.mask;
                    cmd_bus.timing  <= in_flight.timing;
                    if (!quiet && !calm && $urandom_range(0, 5) == 0)
                        cmd_gap = $urandom_range(1, 9);
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
            quiet <= (cmd_backlog.size() < TAIL_ITEMS);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stalls the result channel in random bursts and compares each
    // accepted result item with the oldest prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_check
        dma4_pkg::result_t got;
        dma4_pkg::result_t want;
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.read_data   = rsp_bus.read_data;
                got.copy_valid  = rsp_bus.copy_valid;
                got.copy_source = rsp_bus.copy_source;
                got.copy_dest   = rsp_bus.copy_dest;
                got.copy_word   = rsp_bus.copy_word;
                got.irq_valid   = rsp_bus.irq_valid;
                got.irq_channel = rsp_bus.irq_channel;
                if (predicted_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("ERROR %0t: result item with no command owing it",
                                 $realtime);
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    if (got.read_data !== want.read_data ||
                        got.copy_valid !== want.copy_valid ||
                        got.copy_source !== want.copy_source ||
                        got.copy_dest !== want.copy_dest || got.copy_word !== want.copy_word ||
                        got.irq_valid !== want.irq_valid || got.irq_channel !== want.irq_channel)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display({"ERROR %0t: exp rd=%h copy=%b src=%h dst=%h",
                                      " word=%b irq=%b ch=%0d"},
                                     $realtime, want.read_data, want.copy_valid,
                                     want.copy_source, want.copy_dest, want.copy_word,
                                     want.irq_valid, want.irq_channel);
                            $display({"          got rd=%h copy=%b src=%h dst=%h",
                                      " word=%b irq=%b ch=%0d"},
                                     got.read_data, got.copy_valid, got.copy_source,
                                     got.copy_dest, got.copy_word, got.irq_valid,
                                     got.irq_channel);
                        end
                    end
                end
            end
            if (rsp_gap != 0)
            begin
                rsp_gap--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (!quiet && !calm && $urandom_range(0, 7) == 0)
                    rsp_gap = $urandom_range(1, 9);
            end
        end
    end

    // Watchdog: a run that stops moving items on both channels is hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("four_channel_dma_controller verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        int               ch;
        int               k;
        int               n;
        int               pick;
        logic [REG_W-1:0] len;
        logic [REG_W-1:0] ctl;
        logic [TIM_W-1:0] tim;
        logic [ADDR_W-1:0] addr;

        // Directed part. Reset state first: channel 1 is enabled before any
        // length write, so its count is zero and the first tick completes it
        // without a copy.
        add_item(dma4_pkg::OP_RD_LEN, 0, '0, '0, TIM_NOW);
        add_item(dma4_pkg::OP_WR_CTRL, 1,
                 {16'h0, make_ctrl(1'b1, 1'b1, TIM_NOW, 1'b0, 1'b0,
                                   dma4_pkg::AM_INC, dma4_pkg::AM_INC)},
                 ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        add_item(dma4_pkg::OP_RD_CTRL, 1, '0, '0, TIM_NOW);
        // Word copies whose source wraps past the top of the address space
        // while the destination counts down from all ones.
        add_item(dma4_pkg::OP_WR_SRC, 0, 32'hFFFF_FFFE, ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_WR_DST, 0, ALL_ONES, ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_WR_LEN, 0, 32'h2, ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_WR_CTRL, 0,
                 {16'h0, make_ctrl(1'b1, 1'b1, TIM_NOW, 1'b1, 1'b0,
                                   dma4_pkg::AM_INC, dma4_pkg::AM_DEC)},
                 ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        // Long channel with length zero, a partial source write, fixed source
        // and repeat on the special trigger; disabling drops its pending flag.
        add_item(dma4_pkg::OP_WR_LEN, 3, '0, ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_WR_SRC, 3, 32'hA5A5_A5A5, LOW_HALF, TIM_NOW);
        add_item(dma4_pkg::OP_WR_CTRL, 3,
                 {16'h0, make_ctrl(1'b1, 1'b0, TIM_SPECIAL, 1'b0, 1'b1,
                                   dma4_pkg::AM_FIXED, dma4_pkg::AM_RELOAD)},
                 ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_TRIGGER, 0, '0, '0, TIM_SPECIAL);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        add_item(dma4_pkg::OP_WR_CTRL, 3, '0, EN_BIT, TIM_NOW);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        add_item(dma4_pkg::OP_RD_LEN, 3, '0, '0, TIM_NOW);
        // One-element repeating transfer on vertical blank with destination
        // reload; a horizontal blank trigger must not start it.
        add_item(dma4_pkg::OP_WR_LEN, 2, 32'h1, ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_WR_DST, 2, 32'h0000_1000, ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_WR_CTRL, 2,
                 {16'h0, make_ctrl(1'b1, 1'b1, TIM_VBLANK, 1'b1, 1'b1,
                                   dma4_pkg::AM_DEC, dma4_pkg::AM_RELOAD)},
                 ALL_ONES, TIM_NOW);
        add_item(dma4_pkg::OP_TRIGGER, 0, '0, '0, TIM_HBLANK);
        add_item(dma4_pkg::OP_TRIGGER, 0, '0, '0, TIM_VBLANK);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        add_item(dma4_pkg::OP_TRIGGER, 0, '0, '0, TIM_VBLANK);
        add_item(dma4_pkg::OP_TICK, 0, '0, '0, TIM_NOW);
        // A write with an empty mask changes nothing.
        add_item(dma4_pkg::OP_WR_LEN, 1, ALL_ONES, '0, TIM_NOW);

        // Random part: mostly complete channel set-ups followed by triggers
        // and ticks, mixed with fully random items.
        while (items_made < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                ch = $urandom_range(0, CHANS - 1);
                // Disable first so a long transfer left over from earlier
                // cannot keep a lower channel busy forever.
                if ($urandom_range(0, 2) == 0)
                begin
                    for (k = 0; k < CHANS; k++)
                        add_item(dma4_pkg::OP_WR_CTRL, k, $urandom, EN_BIT & 32'h0000_7FFF,
                                 2'($urandom));
                    for (k = 0; k < CHANS; k++)
                        add_item(dma4_pkg::OP_WR_CTRL, k, '0, EN_BIT, 2'($urandom));
                end
                else
                    add_item(dma4_pkg::OP_WR_CTRL, ch, '0, EN_BIT, 2'($urandom));
                len = ($urandom_range(0, 19) == 0) ? REG_W'($urandom)
                                                   : REG_W'($urandom_range(1, 6));
                add_item(dma4_pkg::OP_WR_LEN, ch, {16'($urandom), len},
                         ($urandom_range(0, 1) == 0) ? ALL_ONES : LOW_HALF, 2'($urandom));
                for (k = 0; k < 2; k++)
                begin
                    pick = $urandom_range(0, 7);
                    if (pick == 0)
                        addr = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
                    else if (pick == 1)
                        addr = 32'($urandom_range(0, 15));
                    else
                        addr = $urandom;
                    add_item(dma4_pkg::op_t'((k == 0) ? dma4_pkg::OP_WR_SRC
                                                      : dma4_pkg::OP_WR_DST),
                             ch, addr,
                             ($urandom_range(0, 5) == 0) ? $urandom : ALL_ONES, 2'($urandom));
                end
                tim = 2'($urandom);
                ctl = make_ctrl(1'b1, 1'($urandom), tim, 1'($urandom), 1'($urandom),
                                dma4_pkg::addr_mode_t'($urandom_range(0, 3)),
                                dma4_pkg::addr_mode_t'($urandom_range(0, 3)));
                // The unused control bits carry random data too.
                ctl = ctl | (REG_W'($urandom) & 16'h081F);
                add_item(dma4_pkg::OP_WR_CTRL, ch, {16'($urandom), ctl},
                         ($urandom_range(0, 3) == 0) ? {16'($urandom), 16'hFFFF} : ALL_ONES,
                         2'($urandom));
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 11)
                        add_item(dma4_pkg::OP_TICK, $urandom_range(0, CHANS - 1), $urandom,
                                 $urandom, 2'($urandom));
                    else if (pick < 16)
                        add_item(dma4_pkg::OP_TRIGGER, $urandom_range(0, CHANS - 1),
                                 $urandom, $urandom,
                                 ($urandom_range(0, 9) < 7) ? tim : 2'($urandom));
                    else
                        add_item(dma4_pkg::op_t'(($urandom_range(0, 1) == 0)
                                                 ? dma4_pkg::OP_RD_LEN
                                                 : dma4_pkg::OP_RD_CTRL),
                                 $urandom_range(0, CHANS - 1), $urandom, $urandom,
                                 2'($urandom));
                end
            end
            else
                add_item(dma4_pkg::op_t'($urandom_range(0, 7)), $urandom_range(0, CHANS - 1),
                         $urandom, ($urandom_range(0, 1) == 0) ? $urandom : ALL_ONES,
                         2'($urandom));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to drain, then for every owed result, then for
        // anything the block might still emit.
        while (cmd_backlog.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (predicted_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && predicted_rsp.size() == 0)
            $display("four_channel_dma_controller verification clean");
        else
            $display("four_channel_dma_controller verification failed");
        $finish;
    end

endmodule

@@ four_channel_dma_controller.f @@
design/dma4_pkg.sv
design/dma4_cmd_if.sv
design/dma4_rsp_if.sv
design/dma4_chan.sv
design/dma4_arb.sv
design/dma4_outq.sv
design/four_channel_dma_controller.sv
verif/tb_four_channel_dma_controller.sv
